// ===== sv/dha_pkg.sv =====
`timescale 1ns / 1ps
// Package for the depth heatmap accumulator: sizes, widths and the control state type.
package dha_pkg;

   localparam int PRICE_ROWS   = 128;
   localparam int HIST_COLUMNS = 256;
   localparam int HALF_ROWS    = 64;

   localparam int QTY_W    = 32;
   localparam int ROW_W    = $clog2(PRICE_ROWS);
   localparam int COL_W    = $clog2(HIST_COLUMNS);
   localparam int FILL_W   = $clog2(HIST_COLUMNS + 1);
   localparam int CELL_AW  = COL_W + ROW_W;
   localparam int CELL_NUM = HIST_COLUMNS * PRICE_ROWS;
   // price difference plus offset, two guard bits for sign and carry
   localparam int DIFF_W   = QTY_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SWEEP,
      ST_LOOKUP,
      ST_UPDATE
   } state_type;

endpackage

// ===== sv/depth_heatmap_accumulator.sv =====
`timescale 1ns / 1ps
// Depth heatmap accumulator: scrolling price-by-time grid with saturating cells and peak tracking.
// Steps: placed level: check, cell read, write; off-window: check, read; mid of zero: check only.
// A snapshot start adds a column-peak walk over all HIST_COLUMNS entries after the check.
// One item at a time; next start taken in the strobe cycle. The receiver cannot stall.
// Reset (synchronous): column 0 newest, grid peak 1, strobe low. No clearing pass: stale cells
//   and column peaks are masked by per-row valid bits and a column fill count.
module depth_heatmap_accumulator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_new_snapshot,
   input  logic [dha_pkg::QTY_W-1:0]  req_mid_price,
   input  logic [dha_pkg::QTY_W-1:0]  req_level_price,
   input  logic signed [dha_pkg::QTY_W-1:0] req_level_quantity,
   output logic                       rsp_valid,
   output logic                       rsp_accepted,
   output logic                       rsp_level_placed,
   output logic [dha_pkg::QTY_W-1:0]  rsp_peak_quantity
);

   // ---------------------------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------------------------
   dha_pkg::state_type state_ff, state_in;

   // latched item
   logic                        snap_ff,  snap_in;
   logic [dha_pkg::QTY_W-1:0]   mid_ff,   mid_in;
   logic [dha_pkg::QTY_W-1:0]   price_ff, price_in;
   logic [dha_pkg::QTY_W-1:0]   qty_ff,   qty_in;

   // ring pointer, count of columns whose peak was ever written, running peaks
   logic [dha_pkg::COL_W-1:0]   newest_ff,   newest_in;
   logic [dha_pkg::FILL_W-1:0]  fill_ff,     fill_in;
   logic [dha_pkg::QTY_W-1:0]   cur_peak_ff, cur_peak_in;   // peak of the newest column
   logic [dha_pkg::QTY_W-1:0]   grid_peak_ff, grid_peak_in;

   // rows of the newest column written since it became newest; others read as zero
   logic [dha_pkg::PRICE_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [dha_pkg::ROW_W-1:0]      row_ff, row_in;

   // column peak walk
   logic [dha_pkg::FILL_W-1:0]  walk_ff, walk_in;
   logic [dha_pkg::QTY_W-1:0]   acc_ff,  acc_in;

   // response registers
   logic                        rsp_valid_ff,  rsp_valid_in;
   logic                        rsp_acc_ff,    rsp_acc_in;
   logic                        rsp_placed_ff, rsp_placed_in;
   logic [dha_pkg::QTY_W-1:0]   rsp_peak_ff,   rsp_peak_in;

   // ---------------------------------------------------------------------------------------
   // Memories: cell grid (column-major, row in low bits) and per-column peaks
   // ---------------------------------------------------------------------------------------
   logic [dha_pkg::QTY_W-1:0]   heat_mem [dha_pkg::CELL_NUM];
   logic [dha_pkg::QTY_W-1:0]   heat_rd_ff;
   logic                        heat_we;
   logic [dha_pkg::CELL_AW-1:0] heat_addr;
   logic [dha_pkg::QTY_W-1:0]   heat_wdata;

   logic [dha_pkg::QTY_W-1:0]   peak_mem [dha_pkg::HIST_COLUMNS];
   logic [dha_pkg::QTY_W-1:0]   peak_rd_ff;
   logic                        peak_we;
   logic [dha_pkg::COL_W-1:0]   peak_waddr;
   logic [dha_pkg::COL_W-1:0]   peak_raddr;

   always_ff @(posedge clock) begin
      if (heat_we) begin
         heat_mem[heat_addr] <= heat_wdata;
      end
      heat_rd_ff <= heat_mem[heat_addr];
   end

   always_ff @(posedge clock) begin
      if (peak_we) begin
         peak_mem[peak_waddr] <= cur_peak_ff;
      end
      peak_rd_ff <= peak_mem[peak_raddr];
   end

   // ---------------------------------------------------------------------------------------
   // Datapath helpers
   // ---------------------------------------------------------------------------------------
   // row = HALF_ROWS + price - mid, exact signed
   logic [dha_pkg::DIFF_W-1:0]  row_full;
   logic                        qty_pos;
   logic                        in_window;
   assign row_full  = {2'b00, price_ff} - {2'b00, mid_ff}
                    + dha_pkg::DIFF_W'(dha_pkg::HALF_ROWS);
   assign qty_pos   = (qty_ff != '0) && !qty_ff[dha_pkg::QTY_W-1];
   assign in_window = !row_full[dha_pkg::DIFF_W-1]
                    && (row_full < dha_pkg::DIFF_W'(dha_pkg::PRICE_ROWS));

   // saturating cell update
   logic [dha_pkg::QTY_W-1:0]   cell_old;
   logic [dha_pkg::QTY_W:0]     cell_sum;
   logic [dha_pkg::QTY_W-1:0]   cell_new;
   assign cell_old = row_valid_ff[row_ff] ? heat_rd_ff : '0;
   assign cell_sum = {1'b0, cell_old} + {1'b0, qty_ff};
   assign cell_new = cell_sum[dha_pkg::QTY_W] ? '1 : cell_sum[dha_pkg::QTY_W-1:0];

   // walk: data on peak_rd_ff belongs to entry walk_ff - 1
   logic [dha_pkg::FILL_W-1:0]  walk_prev;
   logic [dha_pkg::QTY_W-1:0]   walk_cand;
   logic [dha_pkg::QTY_W-1:0]   acc_next;
   assign walk_prev = walk_ff - dha_pkg::FILL_W'(1);
   assign walk_cand = ((walk_ff != '0) && (walk_prev < fill_ff)
                       && (walk_prev[dha_pkg::COL_W-1:0] != newest_ff)) ? peak_rd_ff : '0;
   assign acc_next  = (walk_cand > acc_ff) ? walk_cand : acc_ff;

   // ---------------------------------------------------------------------------------------
   // Next state and outputs
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      snap_in       = snap_ff;
      mid_in        = mid_ff;
      price_in      = price_ff;
      qty_in        = qty_ff;
      newest_in     = newest_ff;
      fill_in       = fill_ff;
      cur_peak_in   = cur_peak_ff;
      grid_peak_in  = grid_peak_ff;
      row_valid_in  = row_valid_ff;
      row_in        = row_ff;
      walk_in       = walk_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = 1'b0;
      rsp_acc_in    = rsp_acc_ff;
      rsp_placed_in = rsp_placed_ff;
      rsp_peak_in   = rsp_peak_ff;

      heat_we    = 1'b0;
      heat_addr  = {newest_ff, row_ff};
      heat_wdata = cell_new;
      peak_we    = 1'b0;
      peak_waddr = newest_ff;
      peak_raddr = walk_ff[dha_pkg::COL_W-1:0];

      unique case (state_ff)
         dha_pkg::ST_IDLE: begin
            if (start) begin
               snap_in  = req_new_snapshot;
               mid_in   = req_mid_price;
               price_in = req_level_price;
               qty_in   = req_level_quantity;
               state_in = dha_pkg::ST_CHECK;
            end
         end

         dha_pkg::ST_CHECK: begin
            if (mid_ff == '0) begin
               // no data: nothing changes, snapshot flag included
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = 1'b0;
               rsp_placed_in = 1'b0;
               rsp_peak_in   = grid_peak_ff;
               state_in      = dha_pkg::ST_IDLE;
            end else if (snap_ff) begin
               // retire the newest column's peak, step the ring, start the peak walk
               peak_we      = 1'b1;
               newest_in    = (newest_ff == dha_pkg::COL_W'(dha_pkg::HIST_COLUMNS - 1))
                            ? '0 : newest_ff + dha_pkg::COL_W'(1);
               fill_in      = (fill_ff == dha_pkg::FILL_W'(dha_pkg::HIST_COLUMNS))
                            ? fill_ff : fill_ff + dha_pkg::FILL_W'(1);
               cur_peak_in  = '0;
               row_valid_in = '0;
               walk_in      = '0;
               acc_in       = dha_pkg::QTY_W'(1);
               state_in     = dha_pkg::ST_SWEEP;
            end else begin
               state_in = dha_pkg::ST_LOOKUP;
            end
         end

         dha_pkg::ST_SWEEP: begin
            acc_in = acc_next;
            if (walk_ff == dha_pkg::FILL_W'(dha_pkg::HIST_COLUMNS)) begin
               grid_peak_in = acc_next;
               state_in     = dha_pkg::ST_LOOKUP;
            end else begin
               walk_in = walk_ff + dha_pkg::FILL_W'(1);
            end
         end

         dha_pkg::ST_LOOKUP: begin
            row_in    = row_full[dha_pkg::ROW_W-1:0];
            heat_addr = {newest_ff, row_full[dha_pkg::ROW_W-1:0]};
            if (qty_pos && in_window) begin
               state_in = dha_pkg::ST_UPDATE;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = 1'b1;
               rsp_placed_in = 1'b0;
               rsp_peak_in   = grid_peak_ff;
               state_in      = dha_pkg::ST_IDLE;
            end
         end

         dha_pkg::ST_UPDATE: begin
            heat_we              = 1'b1;
            row_valid_in[row_ff] = 1'b1;
            if (cell_new > cur_peak_ff) begin
               cur_peak_in = cell_new;
            end
            if (cell_new > grid_peak_ff) begin
               grid_peak_in = cell_new;
               rsp_peak_in  = cell_new;
            end else begin
               rsp_peak_in  = grid_peak_ff;
            end
            rsp_valid_in  = 1'b1;
            rsp_acc_in    = 1'b1;
            rsp_placed_in = 1'b1;
            state_in      = dha_pkg::ST_IDLE;
         end

         default: begin
            state_in = dha_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dha_pkg::ST_IDLE;
         newest_ff    <= '0;
         fill_ff      <= '0;
         cur_peak_ff  <= '0;
         grid_peak_ff <= dha_pkg::QTY_W'(1);
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         newest_ff    <= newest_in;
         fill_ff      <= fill_in;
         cur_peak_ff  <= cur_peak_in;
         grid_peak_ff <= grid_peak_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff       <= snap_in;
      mid_ff        <= mid_in;
      price_ff      <= price_in;
      qty_ff        <= qty_in;
      row_ff        <= row_in;
      walk_ff       <= walk_in;
      acc_ff        <= acc_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_placed_ff <= rsp_placed_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   assign busy              = (state_ff != dha_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_level_placed  = rsp_placed_ff;
   assign rsp_peak_quantity = rsp_peak_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   a_peak_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_quantity != '0))
      else $error("peak below floor");

   a_placed_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_level_placed |-> rsp_accepted)
      else $error("placed item not accepted");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("item not taken on start");

   a_grid_covers_col: assert property (@(posedge clock) disable iff (reset)
      state_ff == dha_pkg::ST_IDLE |-> grid_peak_ff >= cur_peak_ff)
      else $error("grid peak below newest column peak");

endmodule
